>>> hw/rtl/depth_to_point_projector_macros.svh
// Assertion macros shared by the depth-to-point projector checkers.
`ifndef DEPTH_TO_POINT_PROJECTOR_MACROS_SVH
`define DEPTH_TO_POINT_PROJECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define DTPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth_to_point_projector: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define DTPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth_to_point_projector: next-cycle check failed");

`endif

>>> hw/rtl/dtpp_pkg.sv
// Shared types, constants and codes of the depth-to-point projector.
`timescale 1ns / 1ps
package dtpp_pkg;

    // Dimension limit default and register widths
    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    localparam int unsigned DIM_W           = 13;
    localparam int unsigned DIM_MAX         = 8191;
    localparam int unsigned CENTRE_W        = 16;
    localparam int unsigned INV_W           = 24;
    localparam int unsigned DEPTH_W         = 16;
    localparam int unsigned COLOR_W         = 8;
    localparam int unsigned XY_W            = 24;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CFG_DATA_W      = 24;

    // Datapath widths: kept positions stay below 2^13, so pos*16 fits 17 bits
    localparam int unsigned MAG_W   = DIM_W + 4;
    localparam int unsigned MD_W    = MAG_W + DEPTH_W;
    localparam int unsigned PROD_W  = MD_W + INV_W;
    localparam int unsigned FRAC_SH = 20;

    // Request queue between classifier and projection unit
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register reset values
    localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [CENTRE_W-1:0] PRINCIPAL_X_RST  = 16'd15075;
    localparam logic [CENTRE_W-1:0] PRINCIPAL_Y_RST  = 16'd9181;
    localparam logic [INV_W-1:0]    INV_FOCAL_X_RST  = 24'd15510;
    localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST  = 24'd15501;
    localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST    = 16'd1000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_PRINCIPAL_X  = 3'd2,
        REG_PRINCIPAL_Y  = 3'd3,
        REG_INV_FOCAL_X  = 3'd4,
        REG_INV_FOCAL_Y  = 3'd5,
        REG_MAX_DEPTH    = 3'd6
    } reg_index_t;

    // Configuration register set
    typedef struct packed {
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [CENTRE_W-1:0] principal_x;
        logic [CENTRE_W-1:0] principal_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [DEPTH_W-1:0]  max_depth;
    } cfg_t;

    // One classified request for the projection unit
    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic               valid;
        logic               last;
    } item_t;

    // Projection unit sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL_DEPTH,
        BK_MUL_FOCAL,
        BK_EMIT
    } back_state_t;

endpackage

>>> hw/rtl/dtpp_queue.sv
// Small request queue between the pixel classifier and the projection unit.
`timescale 1ns / 1ps
module dtpp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dtpp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output dtpp_pkg::item_t pop_item,
    output logic            empty
);

    dtpp_pkg::item_t                   mem [dtpp_pkg::QUEUE_DEPTH];
    dtpp_pkg::item_t                   pop_item_reg;
    logic [dtpp_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [dtpp_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [dtpp_pkg::QUEUE_AW:0]       count_reg;

    assign full     = (count_reg == (dtpp_pkg::QUEUE_AW + 1)'(dtpp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = pop_item_reg;

    // Store a request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Register the head request as it is dequeued; hold it until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pop_item_reg <= mem[rd_ptr_reg];
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/dtpp_front.sv
// Pixel classifier: raster position, 2x decimation, depth check and offsets.
`timescale 1ns / 1ps
module dtpp_front
#(
    parameter int unsigned MAX_DIM = dtpp_pkg::MAX_DIM_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dtpp_pkg::DEPTH_W-1:0]      depth_mm,
    input  logic [dtpp_pkg::COLOR_W-1:0]      blue_in,
    input  logic [dtpp_pkg::COLOR_W-1:0]      green_in,
    input  logic [dtpp_pkg::COLOR_W-1:0]      red_in,
    input  logic                              start_of_frame,
    input  dtpp_pkg::cfg_t                    cfg,
    input  logic                              queue_full,
    output logic                              push,
    output dtpp_pkg::item_t                   push_item
);

    localparam int unsigned CW    = $clog2(MAX_DIM);
    localparam int unsigned EW    = (((CW + 1) > dtpp_pkg::DIM_W) ? (CW + 1) : dtpp_pkg::DIM_W) + 1;
    localparam int unsigned CLAMP = (MAX_DIM > dtpp_pkg::DIM_MAX) ? dtpp_pkg::DIM_MAX : MAX_DIM;

    logic [CW-1:0]              column_reg;
    logic [CW:0]                row_reg;
    logic [CW-1:0]              column_next;
    logic [CW:0]                row_next;
    logic [CW-1:0]              col;
    logic [CW:0]                row;
    logic [dtpp_pkg::DIM_W-1:0] w_eff;
    logic [dtpp_pkg::DIM_W-1:0] h_eff;
    logic [EW-1:0]              ce;
    logic [EW-1:0]              re;
    logic [EW-1:0]              we;
    logic [EW-1:0]              he;
    logic                       in_range;
    logic                       keep;
    logic                       last;
    logic                       depth_ok;
    logic                       accept;
    logic [dtpp_pkg::MAG_W-1:0] px16;
    logic [dtpp_pkg::MAG_W-1:0] py16;
    logic [dtpp_pkg::MAG_W-1:0] cx;
    logic [dtpp_pkg::MAG_W-1:0] cy;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // Clamp dimensions and pick the position of this pixel
    always_comb
    begin
        w_eff = (cfg.frame_width > dtpp_pkg::DIM_W'(CLAMP)) ? dtpp_pkg::DIM_W'(CLAMP)
                                                            : cfg.frame_width;
        h_eff = (cfg.frame_height > dtpp_pkg::DIM_W'(CLAMP)) ? dtpp_pkg::DIM_W'(CLAMP)
                                                             : cfg.frame_height;
        col   = start_of_frame ? '0 : column_reg;
        row   = start_of_frame ? '0 : row_reg;
        ce    = EW'(col);
        re    = EW'(row);
        we    = EW'(w_eff);
        he    = EW'(h_eff);
    end

    // Decide keep, last and depth validity
    always_comb
    begin
        in_range = (re < he);
        keep     = in_range && !col[0] && !row[0]
                   && ((ce + EW'(2)) <= we) && ((re + EW'(2)) <= he);
        last     = ((ce + EW'(2)) == (we & ~EW'(1))) && ((re + EW'(2)) == (he & ~EW'(1)));
        depth_ok = (depth_mm != '0) && (depth_mm <= cfg.max_depth);
    end

    // Offsets from the principal point as sign and magnitude
    always_comb
    begin
        px16 = {dtpp_pkg::DIM_W'(ce), 4'b0000};
        py16 = {dtpp_pkg::DIM_W'(re), 4'b0000};
        cx   = dtpp_pkg::MAG_W'(cfg.principal_x);
        cy   = dtpp_pkg::MAG_W'(cfg.principal_y);
        push_item.neg_x = (px16 < cx);
        push_item.neg_y = (py16 < cy);
        push_item.mag_x = push_item.neg_x ? (cx - px16) : (px16 - cx);
        push_item.mag_y = push_item.neg_y ? (cy - py16) : (py16 - cy);
        // Zero depth forces zero coordinates downstream
        push_item.depth = depth_ok ? depth_mm : '0;
        push_item.blue  = depth_ok ? blue_in : '0;
        push_item.green = depth_ok ? green_in : '0;
        push_item.red   = depth_ok ? red_in : '0;
        push_item.valid = depth_ok;
        push_item.last  = last;
    end

    assign push = accept && keep;

    // Advance raster position; hold once past the last row
    always_comb
    begin
        column_next = col;
        row_next    = row;
        if (in_range)
        begin
            if (((ce + EW'(1)) >= we) || ((ce + EW'(1)) >= EW'(MAX_DIM)))
            begin
                column_next = '0;
                row_next    = row + (CW + 1)'(1);
            end
            else
            begin
                column_next = CW'(ce + EW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (accept)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

>>> hw/rtl/dtpp_back.sv
// Projection unit: two multiplies per axis, rounding, saturation, output register.
`timescale 1ns / 1ps
module dtpp_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  dtpp_pkg::cfg_t                   cfg,
    input  logic                             queue_empty,
    input  dtpp_pkg::item_t                  queue_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [dtpp_pkg::XY_W-1:0] point_x,
    output logic signed [dtpp_pkg::XY_W-1:0] point_y,
    output logic [dtpp_pkg::DEPTH_W-1:0]     point_z,
    output logic [dtpp_pkg::COLOR_W-1:0]     blue_out,
    output logic [dtpp_pkg::COLOR_W-1:0]     green_out,
    output logic [dtpp_pkg::COLOR_W-1:0]     red_out,
    output logic                             point_valid,
    output logic                             last_of_frame
);

    localparam int unsigned R_W = dtpp_pkg::PROD_W + 1 - dtpp_pkg::FRAC_SH;

    dtpp_pkg::back_state_t              state_reg;
    dtpp_pkg::back_state_t              state_next;
    logic [dtpp_pkg::MD_W-1:0]          md_x_reg;
    logic [dtpp_pkg::MD_W-1:0]          md_y_reg;
    logic [dtpp_pkg::PROD_W-1:0]        prod_x_reg;
    logic [dtpp_pkg::PROD_W-1:0]        prod_y_reg;
    logic                               out_valid_reg;
    logic [dtpp_pkg::XY_W-1:0]          point_x_reg;
    logic [dtpp_pkg::XY_W-1:0]          point_y_reg;
    logic [dtpp_pkg::DEPTH_W-1:0]       point_z_reg;
    logic [dtpp_pkg::COLOR_W-1:0]       blue_reg;
    logic [dtpp_pkg::COLOR_W-1:0]       green_reg;
    logic [dtpp_pkg::COLOR_W-1:0]       red_reg;
    logic                               point_valid_reg;
    logic                               last_reg;
    logic                               out_free;
    logic                               load_md;
    logic                               load_prod;
    logic                               load_out;
    logic [dtpp_pkg::PROD_W:0]          rnd_x;
    logic [dtpp_pkg::PROD_W:0]          rnd_y;
    logic [dtpp_pkg::XY_W-1:0]          sat_x;
    logic [dtpp_pkg::XY_W-1:0]          sat_y;

    // Saturate a rounded magnitude into a signed coordinate
    function automatic logic [dtpp_pkg::XY_W-1:0] sat_xy(input logic neg,
                                                         input logic [R_W-1:0] m);
        if (neg)
        begin
            sat_xy = (m > R_W'(24'h800000)) ? 24'h800000 : (~m[dtpp_pkg::XY_W-1:0] + 24'd1);
        end
        else
        begin
            sat_xy = (m > R_W'(24'h7FFFFF)) ? 24'h7FFFFF : m[dtpp_pkg::XY_W-1:0];
        end
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dtpp_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = dtpp_pkg::BK_MUL_DEPTH;
                end
            end
            dtpp_pkg::BK_MUL_DEPTH: state_next = dtpp_pkg::BK_MUL_FOCAL;
            dtpp_pkg::BK_MUL_FOCAL: state_next = dtpp_pkg::BK_EMIT;
            dtpp_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = dtpp_pkg::BK_IDLE;
                end
            end
            default: state_next = dtpp_pkg::BK_IDLE;
        endcase
    end

    // Sequencer strobes
    always_comb
    begin
        pop       = 1'b0;
        load_md   = 1'b0;
        load_prod = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            dtpp_pkg::BK_IDLE:      pop       = !queue_empty;
            dtpp_pkg::BK_MUL_DEPTH: load_md   = 1'b1;
            dtpp_pkg::BK_MUL_FOCAL: load_prod = 1'b1;
            dtpp_pkg::BK_EMIT:      load_out  = out_free;
            default:                pop       = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpp_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Offset times depth, then times inverse focal length; the queue holds the request
    always_ff @(posedge clk)
    begin
        if (load_md)
        begin
            md_x_reg <= dtpp_pkg::MD_W'(queue_item.mag_x) * dtpp_pkg::MD_W'(queue_item.depth);
            md_y_reg <= dtpp_pkg::MD_W'(queue_item.mag_y) * dtpp_pkg::MD_W'(queue_item.depth);
        end
        if (load_prod)
        begin
            prod_x_reg <= dtpp_pkg::PROD_W'(md_x_reg) * dtpp_pkg::PROD_W'(cfg.inv_focal_x);
            prod_y_reg <= dtpp_pkg::PROD_W'(md_y_reg) * dtpp_pkg::PROD_W'(cfg.inv_focal_y);
        end
    end

    // Round to nearest, ties away from zero, then saturate
    always_comb
    begin
        rnd_x = {1'b0, prod_x_reg} + (dtpp_pkg::PROD_W + 1)'(1 << (dtpp_pkg::FRAC_SH - 1));
        rnd_y = {1'b0, prod_y_reg} + (dtpp_pkg::PROD_W + 1)'(1 << (dtpp_pkg::FRAC_SH - 1));
        sat_x = sat_xy(queue_item.neg_x, rnd_x[dtpp_pkg::PROD_W:dtpp_pkg::FRAC_SH]);
        sat_y = sat_xy(queue_item.neg_y, rnd_y[dtpp_pkg::PROD_W:dtpp_pkg::FRAC_SH]);
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            point_x_reg     <= sat_x;
            point_y_reg     <= sat_y;
            point_z_reg     <= queue_item.depth;
            blue_reg        <= queue_item.blue;
            green_reg       <= queue_item.green;
            red_reg         <= queue_item.red;
            point_valid_reg <= queue_item.valid;
            last_reg        <= queue_item.last;
        end
    end

    // Output request valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = point_x_reg;
    assign point_y       = point_y_reg;
    assign point_z       = point_z_reg;
    assign blue_out      = blue_reg;
    assign green_out     = green_reg;
    assign red_out       = red_reg;
    assign point_valid   = point_valid_reg;
    assign last_of_frame = last_reg;

endmodule

>>> hw/rtl/depth_to_point_projector.sv
// Top level of the depth-to-point projector: registers, classifier, queue, projection unit.
`timescale 1ns / 1ps
// Back-projects a raster depth/colour stream to 3-D points in millimetres.
// Every input pixel is accepted while the request queue (four entries)
// has room; only pixels in even rows and even columns are kept.
// The projection unit handles each kept pixel in order (dequeue, offset
// times depth, times inverse focal length, round and saturate into the
// output register) and takes no new request until it is done, so the
// unit sets the rate. In an even row a kept pixel arrives every second
// pixel, so once the queue fills the input stalls; an odd row passes at
// one pixel per cycle while the queue is not full, as the queue drains.
// Output stalls also hold the projection unit.
// Registers are written through the cfg channel, which is always ready;
// write them only while the block is idle. Index 7 is ignored.
module depth_to_point_projector
#(
    parameter int unsigned MAX_DIM = dtpp_pkg::MAX_DIM_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dtpp_pkg::DEPTH_W-1:0]        depth_mm,
    input  logic [dtpp_pkg::COLOR_W-1:0]        blue_in,
    input  logic [dtpp_pkg::COLOR_W-1:0]        green_in,
    input  logic [dtpp_pkg::COLOR_W-1:0]        red_in,
    input  logic                                start_of_frame,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [dtpp_pkg::XY_W-1:0]    point_x,
    output logic signed [dtpp_pkg::XY_W-1:0]    point_y,
    output logic [dtpp_pkg::DEPTH_W-1:0]        point_z,
    output logic [dtpp_pkg::COLOR_W-1:0]        blue_out,
    output logic [dtpp_pkg::COLOR_W-1:0]        green_out,
    output logic [dtpp_pkg::COLOR_W-1:0]        red_out,
    output logic                                point_valid,
    output logic                                last_of_frame,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dtpp_pkg::cfg_t  cfg_reg;
    dtpp_pkg::item_t push_item;
    dtpp_pkg::item_t pop_item;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= dtpp_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= dtpp_pkg::FRAME_HEIGHT_RST;
            cfg_reg.principal_x  <= dtpp_pkg::PRINCIPAL_X_RST;
            cfg_reg.principal_y  <= dtpp_pkg::PRINCIPAL_Y_RST;
            cfg_reg.inv_focal_x  <= dtpp_pkg::INV_FOCAL_X_RST;
            cfg_reg.inv_focal_y  <= dtpp_pkg::INV_FOCAL_Y_RST;
            cfg_reg.max_depth    <= dtpp_pkg::MAX_DEPTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dtpp_pkg::reg_index_t'(cfg_index))
                dtpp_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width  <= cfg_data[dtpp_pkg::DIM_W-1:0];
                dtpp_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[dtpp_pkg::DIM_W-1:0];
                dtpp_pkg::REG_PRINCIPAL_X:
                    cfg_reg.principal_x  <= cfg_data[dtpp_pkg::CENTRE_W-1:0];
                dtpp_pkg::REG_PRINCIPAL_Y:
                    cfg_reg.principal_y  <= cfg_data[dtpp_pkg::CENTRE_W-1:0];
                dtpp_pkg::REG_INV_FOCAL_X:
                    cfg_reg.inv_focal_x  <= cfg_data[dtpp_pkg::INV_W-1:0];
                dtpp_pkg::REG_INV_FOCAL_Y:
                    cfg_reg.inv_focal_y  <= cfg_data[dtpp_pkg::INV_W-1:0];
                dtpp_pkg::REG_MAX_DEPTH:
                    cfg_reg.max_depth    <= cfg_data[dtpp_pkg::DEPTH_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Classifier
    dtpp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_mm       (depth_mm),
        .blue_in        (blue_in),
        .green_in       (green_in),
        .red_in         (red_in),
        .start_of_frame (start_of_frame),
        .cfg            (cfg_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_item      (push_item)
    );

    // Request queue
    dtpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    // Projection unit
    dtpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .queue_empty   (queue_empty),
        .queue_item    (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .blue_out      (blue_out),
        .green_out     (green_out),
        .red_out       (red_out),
        .point_valid   (point_valid),
        .last_of_frame (last_of_frame)
    );

endmodule

>>> hw/rtl/dtpp_checker.sv
// Port-level checks of the depth-to-point projector, bound to the top level.
`timescale 1ns / 1ps
`include "depth_to_point_projector_macros.svh"
module dtpp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [dtpp_pkg::XY_W-1:0]    point_x,
    input logic signed [dtpp_pkg::XY_W-1:0]    point_y,
    input logic [dtpp_pkg::DEPTH_W-1:0]        point_z,
    input logic [dtpp_pkg::COLOR_W-1:0]        blue_out,
    input logic [dtpp_pkg::COLOR_W-1:0]        green_out,
    input logic [dtpp_pkg::COLOR_W-1:0]        red_out,
    input logic                                point_valid,
    input logic                                last_of_frame
);

    logic                                                              fields_zero;
    logic [2*dtpp_pkg::XY_W+dtpp_pkg::DEPTH_W+3*dtpp_pkg::COLOR_W+1:0] out_payload;

    // Geometry and colour all zero
    assign fields_zero = (point_x == '0) && (point_y == '0) && (point_z == '0)
                         && (blue_out == '0) && (green_out == '0) && (red_out == '0);

    // Whole output request payload
    assign out_payload = {point_x, point_y, point_z, blue_out, green_out, red_out,
                          point_valid, last_of_frame};

    // An out-of-range point carries all-zero geometry and colour
    `DTPP_ASSERT_NOW(a_invalid_zero, out_valid && !point_valid, fields_zero)

    // A valid point always has a measured depth
    `DTPP_ASSERT_NOW(a_valid_depth, out_valid && point_valid, point_z != '0)

    // A stalled point stays put
    `DTPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

endmodule

bind depth_to_point_projector dtpp_checker u_checker (.*);
